>>> sv/rwsc_pkg.sv
// Shared types, codes and constants for the Reno window sender controller.
package rwsc_pkg;

    localparam int SEQ_SPACE = 256;
    localparam int SEQ_W     = $clog2(SEQ_SPACE);

    localparam int DIVD_W = 34;  // mss*mss << 16
    localparam int DIVS_W = 32;  // window in 24.8

    localparam logic [8:0]  SEG_SIZE_RST  = 9'd509;
    localparam logic [15:0] TOTAL_RST     = 16'd0;
    localparam logic [8:0]  LAST_LEN_RST  = 9'd509;
    localparam logic [15:0] TIMEOUT_RST   = 16'd500;
    localparam logic [31:0] CWND_RST      = {15'd0, SEG_SIZE_RST, 8'd0};
    localparam logic [23:0] THR_RST       = {11'd0, SEG_SIZE_RST, 4'd0};

    typedef enum logic [1:0] {
        ACT_SEND  = 2'd0,
        ACT_ACK   = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_START = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_SEG_SIZE = 2'd0,
        CFG_TOTAL    = 2'd1,
        CFG_LAST_LEN = 2'd2,
        CFG_TIMEOUT  = 2'd3
    } t_cfg_index;

    localparam logic [1:0] PH_SLOW_START = 2'd0;
    localparam logic [1:0] PH_CONG_AVOID = 2'd1;
    localparam logic [1:0] PH_FAST_REC   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> sv/rwsc_div.sv
// Restoring divider, one quotient bit per cycle.
module rwsc_div
    import rwsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic [DIVD_W-1:0] o_quotient,
    output t_div_stat         o_stat
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVS_W:0]   w_shift;
    logic [DIVS_W:0]   w_trial;
    logic              w_fit;

    assign w_shift = {r_rem, r_quo[DIVD_W-1]};
    assign w_trial = w_shift - {1'b0, r_div};
    assign w_fit   = w_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], w_fit};
            r_rem <= w_fit ? w_trial[DIVS_W-1:0] : w_shift[DIVS_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> sv/reno_window_sender_control.sv
// Reno congestion controller for a go-back-N sender, top level.
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_ready    | i_action, i_ack_seq, i_ack_good
//  result  | out       | o_out_valid / i_out_ready  | o_send_* , o_window_bytes .. o_transfer_done
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Most words go from acceptance to result through the idle (accept), evaluate and load states.
// A good in-window ACK in congestion avoidance runs the divider for all 34
// quotient bits, and its divide state then folds the quotient into the window
// before that word reaches the load state.
// Reset is synchronous; the send-time store has no reset and is written before it is used.
// A result waiting on i_out_ready holds the block in its load state; config is always ready.
module reno_window_sender_control
    import rwsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_ack_seq,
    input  logic        i_ack_good,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_send_grant,
    output logic [15:0] o_send_index,
    output logic [7:0]  o_send_seq,
    output logic        o_send_final,
    output logic [8:0]  o_send_length,
    output logic [23:0] o_window_bytes,
    output logic [23:0] o_threshold_bytes,
    output logic [1:0]  o_phase,
    output logic        o_went_back,
    output logic        o_transfer_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [8:0]  r_seg_size;
    logic [15:0] r_total;
    logic [8:0]  r_last_len;
    logic [15:0] r_timeout;

    logic [SEQ_W-1:0] r_base, n_base;
    logic [SEQ_W-1:0] r_next, n_next;
    logic [15:0] r_sent, n_sent;
    logic [15:0] r_acked, n_acked;
    logic [31:0] r_cwnd, n_cwnd;
    logic [23:0] r_thr, n_thr;
    logic [1:0]  r_dup, n_dup;
    logic [7:0]  r_prev_ack, n_prev_ack;
    logic [31:0] r_tick, n_tick;

    t_action     r_action;
    logic [7:0]  r_ack;
    logic        r_good;
    logic [24:0] r_used;
    logic [31:0] r_rd_time;

    logic             r_grant, n_grant;
    logic [15:0]      r_idx, n_idx;
    logic [SEQ_W-1:0] r_sq, n_sq;
    logic             r_fin, n_fin;
    logic [8:0]       r_len, n_len;
    logic             r_back, n_back;

    logic [31:0] r_send_times [SEQ_SPACE];

    logic [8:0]        w_mss;
    logic [15:0]       w_outst;
    logic              w_accept;
    logic              w_load;
    logic              w_div_start;
    logic              w_mem_we;
    logic [DIVD_W-1:0] w_quo;
    t_div_stat         w_div_stat;
    logic [17:0]       w_mss_sq;
    logic [31:0]       w_divisor;
    logic [31:0]       w_cwnd_ss;
    logic [34:0]       w_ca_sum;
    logic [23:0]       w_half;
    logic [SEQ_W-1:0]  w_dist;
    logic [31:0]       w_tick_inc;
    logic [31:0]       w_age;

    assign w_mss    = (r_seg_size == 9'd0) ? 9'd1 : r_seg_size;
    assign w_outst  = r_sent - r_acked;
    assign w_accept = i_in_valid && o_in_ready;
    assign w_load   = (r_state == S_DONE) && (!o_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_mss_sq  = w_mss * w_mss;
    assign w_divisor = (r_cwnd == 32'd0) ? 32'd1 : r_cwnd;
    assign w_half    = {1'b0, r_cwnd[31:9]};
    assign w_dist    = SEQ_W'(r_ack) - r_base;
    assign w_tick_inc = r_tick + 32'd1;
    assign w_age      = w_tick_inc - r_rd_time;
    assign w_ca_sum   = {3'd0, r_cwnd} + {1'b0, w_quo};

    // saturating add of one segment in 24.8
    always_comb begin
        logic [32:0] sum;
        sum = {1'b0, r_cwnd} + {16'd0, w_mss, 8'd0};
        w_cwnd_ss = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end

    rwsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_mss_sq, 16'd0}),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_stat     (w_div_stat)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer and state update
    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_next      = r_next;
        n_sent      = r_sent;
        n_acked     = r_acked;
        n_cwnd      = r_cwnd;
        n_thr       = r_thr;
        n_dup       = r_dup;
        n_prev_ack  = r_prev_ack;
        n_tick      = r_tick;
        n_grant     = r_grant;
        n_idx       = r_idx;
        n_sq        = r_sq;
        n_fin       = r_fin;
        n_len       = r_len;
        n_back      = r_back;
        w_div_start = 1'b0;
        w_mem_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_grant = 1'b0;
                    n_idx   = '0;
                    n_sq    = '0;
                    n_fin   = 1'b0;
                    n_len   = '0;
                    n_back  = 1'b0;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                case (r_action)
                    ACT_SEND: begin
                        if (({r_used, 8'd0} < {1'b0, r_cwnd}) && (r_sent < r_total) &&
                            (w_outst < 16'(SEQ_SPACE - 1))) begin
                            n_grant  = 1'b1;
                            n_idx    = r_sent;
                            n_sq     = r_next;
                            n_fin    = ({1'b0, r_sent} + 17'd1) == {1'b0, r_total};
                            n_len    = n_fin ? r_last_len : r_seg_size;
                            w_mem_we = 1'b1;
                            n_next   = r_next + 1'b1;
                            n_sent   = r_sent + 16'd1;
                        end
                    end
                    ACT_ACK: begin
                        if (r_good) begin
                            if (16'(w_dist) < w_outst) begin
                                n_base  = r_base + w_dist + 1'b1;
                                n_acked = r_acked + 16'(w_dist) + 16'd1;
                                n_dup   = 2'd0;
                                if (r_dup == 2'd3) begin
                                    n_cwnd = {r_thr, 8'd0};
                                end else if (r_cwnd[31:8] < r_thr) begin
                                    n_cwnd = w_cwnd_ss;
                                end else begin
                                    w_div_start = 1'b1;
                                    n_state     = S_DIV;
                                end
                            end else if (r_ack == r_prev_ack) begin
                                if (r_dup == 2'd3) begin
                                    n_cwnd = w_cwnd_ss;
                                end else begin
                                    n_dup = r_dup + 2'd1;
                                    if (r_dup == 2'd2) begin
                                        // third duplicate: halve and go back
                                        n_thr  = w_half;
                                        n_cwnd = {w_half + 24'(3 * w_mss), 8'd0};
                                        n_next = r_base;
                                        n_sent = r_acked;
                                        n_back = 1'b1;
                                    end
                                end
                            end
                            n_prev_ack = r_ack;
                        end
                    end
                    ACT_TICK: begin
                        n_tick = w_tick_inc;
                        if ((w_outst != 16'd0) && (w_age > {16'd0, r_timeout})) begin
                            n_next = r_base;
                            n_sent = r_acked;
                            n_thr  = w_half;
                            n_cwnd = {15'd0, w_mss, 8'd0};
                            n_dup  = 2'd0;
                            n_back = 1'b1;
                        end
                    end
                    ACT_START: begin
                        n_sent     = '0;
                        n_acked    = '0;
                        n_prev_ack = '0;
                        n_next     = r_base;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_cwnd  = (w_ca_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : w_ca_sum[31:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_size <= SEG_SIZE_RST;
            r_total    <= TOTAL_RST;
            r_last_len <= LAST_LEN_RST;
            r_timeout  <= TIMEOUT_RST;
            r_base     <= SEQ_W'(1);
            r_next     <= SEQ_W'(1);
            r_sent     <= '0;
            r_acked    <= '0;
            r_cwnd     <= CWND_RST;
            r_thr      <= THR_RST;
            r_dup      <= '0;
            r_prev_ack <= '0;
            r_tick     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_base     <= n_base;
            r_next     <= n_next;
            r_sent     <= n_sent;
            r_acked    <= n_acked;
            r_cwnd     <= n_cwnd;
            r_thr      <= n_thr;
            r_dup      <= n_dup;
            r_prev_ack <= n_prev_ack;
            r_tick     <= n_tick;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SEG_SIZE: r_seg_size <= i_cfg_data[8:0];
                    CFG_TOTAL:    r_total    <= i_cfg_data;
                    CFG_LAST_LEN: r_last_len <= i_cfg_data[8:0];
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload and output registers, captured inputs and the send-time store
    always_ff @(posedge i_clk) begin
        r_grant <= n_grant;
        r_idx   <= n_idx;
        r_sq    <= n_sq;
        r_fin   <= n_fin;
        r_len   <= n_len;
        r_back  <= n_back;
        if (w_accept) begin
            r_action  <= t_action'(i_action);
            r_ack     <= i_ack_seq;
            r_good    <= i_ack_good;
            r_used    <= w_outst * w_mss;
            r_rd_time <= r_send_times[r_base];
        end
        if (w_mem_we) begin
            r_send_times[r_next] <= r_tick;
        end
        if (w_load) begin
            o_send_grant      <= r_grant;
            o_send_index      <= r_idx;
            o_send_seq        <= 8'(r_sq);
            o_send_final      <= r_fin;
            o_send_length     <= r_len;
            o_window_bytes    <= r_cwnd[31:8];
            o_threshold_bytes <= r_thr;
            o_phase           <= (r_dup == 2'd3) ? PH_FAST_REC :
                                 ((r_cwnd[31:8] < r_thr) ? PH_SLOW_START : PH_CONG_AVOID);
            o_went_back       <= r_back;
            o_transfer_done   <= r_acked >= r_total;
        end
    end

endmodule
